// ----- hdl/bit_field_frame_builder_crc32_macros.svh -----
// Assertion macros shared by the frame builder modules
`ifndef BIT_FIELD_FRAME_BUILDER_CRC32_MACROS_SVH
`define BIT_FIELD_FRAME_BUILDER_CRC32_MACROS_SVH
// same-cycle implication
`define BFFB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define BFFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- hdl/bffb_pkg.sv -----
// Types, constants and CRC step function for the frame builder
`default_nettype none
package bffb_pkg;
	localparam int FRAME_BYTES = 32;
	localparam int FRAME_BITS = FRAME_BYTES * 8;
	localparam int IDX_W = $clog2(FRAME_BYTES);
	localparam int CRC_BYTES = 4;
	localparam int CRC_SPAN = FRAME_BYTES - CRC_BYTES;
	localparam int MAX_LEN = 32;
	localparam int WIDE_W = FRAME_BITS + MAX_LEN;
	localparam int OFF_W = 9;
	localparam int LEN_W = 6;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int APB_AW = 3;
	localparam logic [31:0] CRC_POLY = 32'h04C11DB7;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
	localparam logic REG_SYNC = 1'b0;

	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_FIELD = 2'd1;
	localparam logic [1:0] ACT_FINISH = 2'd2;

	typedef struct packed {
		logic [1:0]       action;
		logic [OFF_W-1:0] field_pos;
		logic [LEN_W-1:0] field_len;
		logic [31:0]      field_value;
	} item_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} result_t;

	typedef enum logic [1:0] {OP_START, OP_FIELD, OP_FINISH} op_t;

	typedef struct packed {
		op_t              op;
		logic [OFF_W-1:0] offset;
		logic [LEN_W-1:0] length;
		logic [31:0]      value;
	} cmd_t;

	typedef enum logic [1:0] {ST_IDLE, ST_CRC, ST_TAIL} state_t;

	// one byte of CRC-32/MPEG-2, MSB first
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
		logic [31:0] c;
		c = crc ^ {data, 24'd0};
		for (int k = 0; k < 8; k++) begin
			c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction
endpackage
`default_nettype wire

// ----- hdl/bffb_fifo.sv -----
// Two-entry command queue between front and back
`default_nettype none
`include "bit_field_frame_builder_crc32_macros.svh"
module bffb_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire bffb_pkg::cmd_t wdata,
	input  wire logic          pop,
	output bffb_pkg::cmd_t     rdata,
	output logic               empty,
	output logic               full
);
	import bffb_pkg::*;

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`BFFB_ASSERT_IMPL(a_no_overflow, clk, arst_n, push, !full, "push into full queue")
	`BFFB_ASSERT_IMPL(a_no_underflow, clk, arst_n, pop, !empty, "pop from empty queue")
	`BFFB_ASSERT_IMPL(a_count_range, clk, arst_n, 1'b1, count_q <= QCNT_W'(QUEUE_DEPTH), "queue count out of range")
endmodule
`default_nettype wire

// ----- hdl/bffb_front.sv -----
// Front end: accepts items and turns them into queue commands
`default_nettype none
module bffb_front (
	input  wire logic           start,
	input  wire logic           busy,
	input  wire bffb_pkg::item_t item,
	input  wire logic [31:0]    sync_word,
	output logic                push,
	output bffb_pkg::cmd_t      entry
);
	import bffb_pkg::*;

	logic accept;
	assign accept = start && !busy;

	always_comb begin
		push         = 1'b0;
		entry.op     = OP_FIELD;
		entry.offset = item.field_pos;
		entry.length = item.field_len;
		entry.value  = item.field_value;
		unique case (item.action)
			ACT_START: begin
				push        = accept;
				entry.op    = OP_START;
				entry.value = sync_word;
			end
			ACT_FIELD: begin
				// empty or overlong fields are dropped here
				push = accept && (item.field_len != '0)
					&& (item.field_len <= LEN_W'(MAX_LEN));
			end
			ACT_FINISH: begin
				push     = accept;
				entry.op = OP_FINISH;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end
endmodule
`default_nettype wire

// ----- hdl/bffb_back.sv -----
// Back end: frame store, field writes, CRC walk and byte output
`default_nettype none
`include "bit_field_frame_builder_crc32_macros.svh"
module bffb_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire bffb_pkg::cmd_t head,
	input  wire logic           empty,
	output logic                pop,
	output logic                strobe,
	output bffb_pkg::result_t   result
);
	import bffb_pkg::*;

	state_t            st_q, st_d;
	logic [IDX_W-1:0]  idx_q;
	logic [31:0]       crc_q, crc_next;
	logic [FRAME_BITS-1:0] frame_q, field_frame;
	logic [MAX_LEN-1:0] len_mask;
	logic [WIDE_W-1:0] wide_mask, wide_data;
	logic [7:0]        cur_byte;
	logic              emit, last;
	logic              strobe_q;
	result_t           result_q;

	assign cur_byte = frame_q[{idx_q, 3'b000} +: 8];
	assign crc_next = crc_byte(crc_q, cur_byte);

	assign len_mask    = {MAX_LEN{1'b1}} >> (LEN_W'(MAX_LEN) - head.length);
	assign wide_mask   = WIDE_W'(len_mask) << head.offset;
	assign wide_data   = WIDE_W'(head.value & len_mask) << head.offset;
	assign field_frame = (frame_q & ~wide_mask[FRAME_BITS-1:0]) | wide_data[FRAME_BITS-1:0];

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (!empty && head.op == OP_FINISH) begin
					st_d = ST_CRC;
				end
			end
			ST_CRC: begin
				if (idx_q == IDX_W'(CRC_SPAN - 1)) begin
					st_d = ST_TAIL;
				end
			end
			ST_TAIL: begin
				if (idx_q == IDX_W'(FRAME_BYTES - 1)) begin
					st_d = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		pop  = 1'b0;
		emit = 1'b0;
		last = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				pop = !empty;
			end
			ST_CRC: begin
				emit = 1'b1;
			end
			ST_TAIL: begin
				emit = 1'b1;
				last = (idx_q == IDX_W'(FRAME_BYTES - 1));
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			idx_q    <= '0;
			crc_q    <= CRC_INIT;
			frame_q  <= '0;
			strobe_q <= 1'b0;
		end else begin
			st_q     <= st_d;
			strobe_q <= emit;
			if (pop) begin
				idx_q <= '0;
				case (head.op)
					OP_START: begin
						frame_q <= FRAME_BITS'(head.value);
						crc_q   <= CRC_INIT;
					end
					OP_FIELD: begin
						frame_q <= field_frame;
					end
					default: begin
						crc_q <= CRC_INIT;
					end
				endcase
			end else if (emit) begin
				idx_q <= idx_q + 1'b1;
			end
			if (st_q == ST_CRC) begin
				crc_q <= crc_next;
				if (idx_q == IDX_W'(CRC_SPAN - 1)) begin
					frame_q[CRC_SPAN*8 +: 32] <= crc_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		result_q.frame_byte <= cur_byte;
		result_q.last_byte  <= last;
	end

	assign strobe = strobe_q;
	assign result = result_q;

	`BFFB_ASSERT_NEXT(a_walk_emits, clk, arst_n, st_q != ST_IDLE, strobe_q, "walk cycle without beat")
	`BFFB_ASSERT_IMPL(a_pop_idle, clk, arst_n, pop, st_q == ST_IDLE, "pop during frame walk")
	`BFFB_ASSERT_IMPL(a_last_tail, clk, arst_n, strobe_q && result_q.last_byte, $past(st_q) == ST_TAIL, "last beat outside trailer")
endmodule
`default_nettype wire

// ----- hdl/bit_field_frame_builder_crc32.sv -----
// Start and field items take effect at the edge that pops them, which the back end does only while idle.
// Finish: the back end pops the item, walks the CRC span, then the trailer,
// emitting one byte per cycle, FRAME_BYTES bytes in all; it pops nothing while walking.
// Queueing: the two-entry queue absorbs items while a frame is walked; busy when full.
// Reset: frame store cleared to zeros, sync word zero, queue empty, no strobe.
`default_nettype none
module bit_field_frame_builder_crc32 (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire bffb_pkg::item_t              item,
	output logic                              strobe,
	output bffb_pkg::result_t                 result,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [bffb_pkg::APB_AW-1:0]  paddr,
	input  wire logic [31:0]                  pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);
	import bffb_pkg::*;

	logic [31:0] sync_q;
	logic        push, pop, empty, full;
	cmd_t        entry, head;

	assign pready = 1'b1;
	assign prdata = (paddr[APB_AW-1:2] == REG_SYNC) ? sync_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= '0;
		end else if (psel && penable && pwrite && paddr[APB_AW-1:2] == REG_SYNC) begin
			sync_q <= pwdata;
		end
	end

	assign busy = full;

	bffb_front u_front (
		.start     (start),
		.busy      (full),
		.item      (item),
		.sync_word (sync_q),
		.push      (push),
		.entry     (entry)
	);

	bffb_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (entry),
		.pop    (pop),
		.rdata  (head),
		.empty  (empty),
		.full   (full)
	);

	bffb_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.strobe (strobe),
		.result (result)
	);
endmodule
`default_nettype wire
